// ===== sv/nmk_pkg.sv =====
// ============================================================================
// nmk_pkg: shared types and constants of the Newmark integrator
// Control bundles passed between pipeline parts, the coefficient set derived
// from the configuration registers, and the register index codes.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package nmk_pkg;

	localparam int VAL_W    = 32;
	localparam int DOF_IN_W = 12;
	localparam int COEF_W   = 17;

	localparam logic [COEF_W-1:0] COEF_ONE = 17'd65536;

	typedef enum logic [1:0] {
		REG_TIME_STEP = 2'd0,
		REG_BETA      = 2'd1,
		REG_GAMMA     = 2'd2
	} reg_idx_t;

	// Control bits that travel with every item behind the divider.
	typedef struct packed {
		logic valid;
		logic func;    // 0 predict, 1 correct
		logic mpos;    // node mass is positive
		logic an_sat;  // new acceleration was clipped
	} ctl_t;

	// Step size terms and clamped Newmark coefficients.
	typedef struct packed {
		logic [VAL_W-1:0]  dt;
		logic [VAL_W-1:0]  dt2;
		logic [VAL_W-1:0]  hdt2;
		logic [COEF_W-1:0] beta;
		logic [COEF_W-1:0] gamma;
	} coef_t;

endpackage

`default_nettype wire

// ===== sv/nmk_div.sv =====
// ============================================================================
// nmk_div: pipelined acceleration divider
// Forms residual * 2^FRAC_BITS / mass rounded to nearest, one quotient bit per
// stage, saturates it, and reduces the dof index modulo the store depth.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module nmk_div #(
	parameter int FRAC_BITS = 16,
	parameter int NUM_DOF   = 4096,
	parameter int IDX_W     = 12
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           en,
	input  wire logic                           in_valid,
	input  wire logic                           in_func,
	input  wire logic [nmk_pkg::DOF_IN_W-1:0]   in_dof,
	input  wire logic [nmk_pkg::VAL_W-1:0]      in_res,
	input  wire logic [nmk_pkg::VAL_W-1:0]      in_mass,
	output nmk_pkg::ctl_t                       out_ctl,
	output logic [IDX_W-1:0]                    out_idx,
	output logic [nmk_pkg::VAL_W-1:0]           out_an
);

	localparam int NUM_W     = FRAC_BITS + 34;
	localparam int NST       = 32;
	localparam int XW        = nmk_pkg::DOF_IN_W;
	localparam int MOD_STEPS = nmk_pkg::DOF_IN_W;

	// Stage 1: captured input.
	logic             vld_s1;
	logic             func_s1;
	logic [XW-1:0]    dof_s1;
	logic [31:0]      res_s1;
	logic [31:0]      mass_s1;

	// Stage 2: dividend and divisor.
	logic             vld_s2;
	logic             func_s2;
	logic [XW-1:0]    dof_s2;
	logic             neg_s2;
	logic             mpos_s2;
	logic [NUM_W-1:0] num_s2;
	logic [31:0]      den_s2;

	// Division steps; entry 0 holds the initial partial remainder.
	logic             step_vld_s  [NST+1];
	logic [31:0]      step_rem_s  [NST+1];
	logic [31:0]      step_lo_s   [NST+1];
	logic [31:0]      step_den_s  [NST+1];
	logic [XW-1:0]    step_x_s    [NST+1];
	logic             step_neg_s  [NST+1];
	logic             step_mpos_s [NST+1];
	logic             step_func_s [NST+1];
	logic             step_ovf_s  [NST+1];

	logic [31:0]      rmag;
	logic [NUM_W-1:0] num_nx;
	logic [31:0]      q;
	logic             q_ovf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			step_vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			step_vld_s[0] <= vld_s2;
		end
	end

	assign rmag   = res_s1[31] ? 32'(-res_s1) : res_s1;
	// Adding the mass before dividing by twice the mass rounds to nearest.
	assign num_nx = (NUM_W'(rmag) << (FRAC_BITS + 1)) + NUM_W'(mass_s1[30:0]);

	always_ff @(posedge clk) begin
		if (en) begin
			func_s1 <= in_func;
			dof_s1  <= in_dof;
			res_s1  <= in_res;
			mass_s1 <= in_mass;

			func_s2 <= func_s1;
			dof_s2  <= dof_s1;
			neg_s2  <= res_s1[31];
			mpos_s2 <= ~mass_s1[31] & (|mass_s1);
			num_s2  <= num_nx;
			den_s2  <= {mass_s1[30:0], 1'b0};

			// A quotient of 2^32 or more is clipped anyway.
			step_ovf_s[0]  <= (num_s2 >> 32) >= NUM_W'(den_s2);
			step_rem_s[0]  <= 32'(num_s2 >> 32);
			step_lo_s[0]   <= num_s2[31:0];
			step_den_s[0]  <= den_s2;
			step_x_s[0]    <= dof_s2;
			step_neg_s[0]  <= neg_s2;
			step_mpos_s[0] <= mpos_s2;
			step_func_s[0] <= func_s2;
		end
	end

	for (genvar k = 0; k < NST; k++) begin : g_step
		logic [32:0]   r2;
		logic          ge;
		logic [XW-1:0] x_nx;

		assign r2 = {step_rem_s[k], step_lo_s[k][31]};
		assign ge = r2 >= {1'b0, step_den_s[k]};

		if (k < MOD_STEPS) begin : g_mod
			localparam longint unsigned MODK =
				longint'(NUM_DOF) << (MOD_STEPS - 1 - k);
			assign x_nx = (64'(step_x_s[k]) >= MODK) ?
				step_x_s[k] - XW'(MODK) : step_x_s[k];
		end else begin : g_nomod
			assign x_nx = step_x_s[k];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				step_vld_s[k+1] <= 1'b0;
			end else if (en) begin
				step_vld_s[k+1] <= step_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				step_rem_s[k+1]  <= ge ? 32'(r2 - {1'b0, step_den_s[k]}) : r2[31:0];
				step_lo_s[k+1]   <= {step_lo_s[k][30:0], ge};
				step_den_s[k+1]  <= step_den_s[k];
				step_x_s[k+1]    <= x_nx;
				step_neg_s[k+1]  <= step_neg_s[k];
				step_mpos_s[k+1] <= step_mpos_s[k];
				step_func_s[k+1] <= step_func_s[k];
				step_ovf_s[k+1]  <= step_ovf_s[k];
			end
		end
	end

	assign q     = step_lo_s[NST];
	assign q_ovf = step_ovf_s[NST] |
		(step_neg_s[NST] ? (q > 32'h8000_0000) : (q > 32'h7FFF_FFFF));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ctl <= '0;
		end else if (en) begin
			out_ctl.valid  <= step_vld_s[NST];
			out_ctl.func   <= step_func_s[NST];
			out_ctl.mpos   <= step_mpos_s[NST];
			out_ctl.an_sat <= q_ovf;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_idx <= IDX_W'(step_x_s[NST]);
			if (q_ovf) begin
				out_an <= step_neg_s[NST] ? 32'h8000_0000 : 32'h7FFF_FFFF;
			end else begin
				out_an <= step_neg_s[NST] ? 32'(-q) : q;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/nmk_update.sv =====
// ============================================================================
// nmk_update: Newmark state update datapath
// Five stages: coefficient products, weighted sums, step size products,
// rounding, final sums with saturation.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module nmk_update #(
	parameter int IDX_W = 12
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   en,
	input  wire nmk_pkg::coef_t         coef,
	input  wire nmk_pkg::ctl_t          d_ctl,
	input  wire logic [IDX_W-1:0]       d_idx,
	input  wire logic [31:0]            d_an,
	input  wire logic [31:0]            d_u,
	input  wire logic [31:0]            d_v,
	input  wire logic [31:0]            d_a,
	input  wire logic [IDX_W-1:0]       probe_idx,
	output logic                        conflict,
	output nmk_pkg::ctl_t               g_ctl,
	output logic [IDX_W-1:0]            g_idx,
	output logic [31:0]                 g_u,
	output logic [31:0]                 g_v,
	output logic [31:0]                 g_a,
	output logic                        g_sat
);

	function automatic logic signed [35:0] rnd16(input logic signed [51:0] x);
		logic [51:0] mag;
		logic [51:0] r;
		mag = x[51] ? 52'(-x) : 52'(x);
		r   = (mag + 52'd32768) >> 16;
		return x[51] ? -$signed(36'(r)) : $signed(36'(r));
	endfunction

	function automatic logic ovf37(input logic [36:0] x);
		return (x[36:31] != 6'h00) && (x[36:31] != 6'h3F);
	endfunction

	function automatic logic [31:0] sat37(input logic [36:0] x);
		if (!ovf37(x)) begin
			return x[31:0];
		end
		return x[36] ? 32'h8000_0000 : 32'h7FFF_FFFF;
	endfunction

	nmk_pkg::ctl_t     ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic [IDX_W-1:0]  idx_s1, idx_s2, idx_s3, idx_s4;
	logic [31:0]       u_s1, u_s2, u_s3, u_s4;
	logic [31:0]       v_s1, v_s2, v_s3, v_s4;
	logic [31:0]       ra_s1, ra_s2, ra_s3, ra_s4;

	// Stage 1 products.
	logic signed [50:0] pua_s1, pun_s1, pva_s1, pvn_s1;
	// Stage 2 magnitudes and signs.
	logic [32:0]        wum_s2, wvm_s2, vm_s2;
	logic               wun_s2, wvn_s2, vn_s2;
	// Stage 3 magnitude products.
	logic [64:0]        muv_s3, muw_s3, mvw_s3;
	logic               wun_s3, wvn_s3, vn_s3;
	// Stage 4 signed terms.
	logic signed [34:0] tuv_s4, tuw_s4, tvw_s4;

	logic signed [18:0] bex, gex, cu, cv;
	logic signed [31:0] a_old, an_op;
	logic signed [51:0] sumu, sumv;
	logic signed [35:0] wu, wv;
	logic [33:0]        ruv, ruw, rvw;
	logic [36:0]        su, sv;
	logic               ovu, ovv;

	assign bex   = $signed({2'b00, coef.beta});
	assign gex   = $signed({2'b00, coef.gamma});
	// Predict weighs a by 1-2*beta; correct weighs a_old by 1/2-beta.
	assign cu    = d_ctl.func ? (19'sd32768 - bex) : (19'sd65536 - (bex <<< 1));
	assign cv    = 19'sd65536 - gex;
	assign a_old = $signed(d_a);
	assign an_op = (d_ctl.func & d_ctl.mpos) ? $signed(d_an) : 32'sd0;

	assign sumu  = {pua_s1[50], pua_s1} + {pun_s1[50], pun_s1};
	assign sumv  = {pva_s1[50], pva_s1} + {pvn_s1[50], pvn_s1};
	assign wu    = rnd16(sumu);
	assign wv    = rnd16(sumv);

	assign ruv   = 34'((muv_s3 + 65'h0_8000_0000) >> 32);
	assign ruw   = 34'((muw_s3 + 65'h0_8000_0000) >> 32);
	assign rvw   = 34'((mvw_s3 + 65'h0_8000_0000) >> 32);

	assign su    = {{5{u_s4[31]}}, u_s4} + 37'($unsigned(tuv_s4)) +
		37'($unsigned(tuw_s4)) + {{2{tuv_s4[34]}}, 35'd0} + {{2{tuw_s4[34]}}, 35'd0};
	assign sv    = {{5{v_s4[31]}}, v_s4} + 37'($unsigned(tvw_s4)) +
		{{2{tvw_s4[34]}}, 35'd0};
	assign ovu   = ovf37(su);
	assign ovv   = ovf37(sv);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			g_ctl  <= '0;
		end else if (en) begin
			ctl_s1 <= d_ctl;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			g_ctl  <= ctl_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s1 <= d_idx;
			u_s1   <= d_u;
			v_s1   <= d_v;
			ra_s1  <= d_ctl.func ? an_op : d_a;
			pua_s1 <= cu * a_old;
			pun_s1 <= bex * an_op;
			pva_s1 <= cv * a_old;
			pvn_s1 <= gex * an_op;

			idx_s2 <= idx_s1;
			u_s2   <= u_s1;
			v_s2   <= v_s1;
			ra_s2  <= ra_s1;
			wun_s2 <= wu[35];
			wum_s2 <= wu[35] ? 33'(-wu) : 33'(wu);
			wvn_s2 <= wv[35];
			wvm_s2 <= wv[35] ? 33'(-wv) : 33'(wv);
			vn_s2  <= v_s1[31];
			vm_s2  <= v_s1[31] ? 33'(-$signed({v_s1[31], v_s1})) : {1'b0, v_s1};

			idx_s3 <= idx_s2;
			u_s3   <= u_s2;
			v_s3   <= v_s2;
			ra_s3  <= ra_s2;
			wun_s3 <= wun_s2;
			wvn_s3 <= wvn_s2;
			vn_s3  <= vn_s2;
			muv_s3 <= 65'(vm_s2) * 65'(coef.dt);
			muw_s3 <= 65'(wum_s2) * 65'(ctl_s2.func ? coef.dt2 : coef.hdt2);
			mvw_s3 <= 65'(wvm_s2) * 65'(coef.dt);

			idx_s4 <= idx_s3;
			u_s4   <= u_s3;
			v_s4   <= v_s3;
			ra_s4  <= ra_s3;
			tuv_s4 <= vn_s3  ? -$signed({1'b0, ruv}) : $signed({1'b0, ruv});
			tuw_s4 <= wun_s3 ? -$signed({1'b0, ruw}) : $signed({1'b0, ruw});
			tvw_s4 <= wvn_s3 ? -$signed({1'b0, rvw}) : $signed({1'b0, rvw});

			g_idx <= idx_s4;
			g_a   <= ra_s4;
			if (ctl_s4.func && !ctl_s4.mpos) begin
				g_u   <= u_s4;
				g_v   <= v_s4;
				g_sat <= 1'b0;
			end else if (ctl_s4.func) begin
				g_u   <= sat37(su);
				g_v   <= sat37(sv);
				g_sat <= ctl_s4.an_sat | ovu | ovv;
			end else begin
				g_u   <= sat37(su);
				g_v   <= v_s4;
				g_sat <= ovu;
			end
		end
	end

	// Any correct transaction in flight still has to write its dof back.
	assign conflict =
		(ctl_s1.valid & ctl_s1.func & (idx_s1 == probe_idx)) |
		(ctl_s2.valid & ctl_s2.func & (idx_s2 == probe_idx)) |
		(ctl_s3.valid & ctl_s3.func & (idx_s3 == probe_idx)) |
		(ctl_s4.valid & ctl_s4.func & (idx_s4 == probe_idx)) |
		(g_ctl.valid  & g_ctl.func  & (g_idx  == probe_idx));

endmodule

`default_nettype wire

// ===== sv/newmark_dof_integrator.sv =====
// ============================================================================
// newmark_dof_integrator: per degree of freedom Newmark-beta integrator
// Streams predict and correct transactions against displacement, velocity and
// acceleration stores, one result per transaction.
// ============================================================================
// The block takes one transaction per clock while its output is not stalled
// and returns each result through the bit-per-stage acceleration divider, the
// state store read, five update stages and the output register. A transaction
// that addresses a dof still being corrected by an earlier transaction is held
// at the store read until that write lands; transactions to other dofs flow at
// full rate. After reset the stores are cleared one entry per cycle, each of
// the NUM_DOF entries in turn, with s_tready low; configuration writes are
// taken at any time and should be issued while the pipeline is empty.
`timescale 1ns / 1ps
`default_nettype none

module newmark_dof_integrator #(
	parameter int NUM_DOF   = 4096,
	parameter int FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [79:0] s_tdata,   // dof_index, residual_force, node_mass
	input  wire logic [0:0]  s_tuser,   // func
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [95:0]      m_tdata,   // out_displacement, out_velocity, out_acceleration
	output logic [0:0]       m_tuser,   // saturated
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	localparam int IDX_W = $clog2(NUM_DOF);

	logic [31:0] time_step_q;
	logic [16:0] beta_q;
	logic [16:0] gamma_q;
	logic [63:0] dt_sq_q;
	nmk_pkg::coef_t coef_q;

	logic             clr_busy_q;
	logic [IDX_W-1:0] clr_addr_q;

	logic adv;
	logic hazard;
	logic div_en;

	nmk_pkg::ctl_t    r_ctl;
	logic [IDX_W-1:0] r_idx;
	logic [31:0]      r_an;

	nmk_pkg::ctl_t    d_ctl_s1;
	logic [IDX_W-1:0] d_idx_s1;
	logic [31:0]      d_an_s1;
	logic [31:0]      d_u_s1, d_v_s1, d_a_s1;

	logic             upd_conflict;
	nmk_pkg::ctl_t    g_ctl;
	logic [IDX_W-1:0] g_idx;
	logic [31:0]      g_u, g_v, g_a;
	logic             g_sat;

	logic             out_vld_q;
	logic [95:0]      out_data_q;
	logic             out_sat_q;

	logic             we;
	logic [IDX_W-1:0] wr_addr;
	logic [31:0]      wr_u, wr_v, wr_a;

	logic [31:0] disp_mem  [NUM_DOF];
	logic [31:0] vel_mem   [NUM_DOF];
	logic [31:0] accel_mem [NUM_DOF];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= '0;
			beta_q      <= '0;
			gamma_q     <= 17'd32768;
		end else if (cfg_valid) begin
			unique case (nmk_pkg::reg_idx_t'(cfg_index))
				nmk_pkg::REG_TIME_STEP: time_step_q <= cfg_data;
				nmk_pkg::REG_BETA:      beta_q      <= cfg_data[16:0];
				nmk_pkg::REG_GAMMA:     gamma_q     <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		dt_sq_q     <= 64'(time_step_q) * 64'(time_step_q);
		coef_q.dt   <= time_step_q;
		coef_q.dt2  <= 32'((dt_sq_q + 64'h0000_0000_8000_0000) >> 32);
		coef_q.hdt2 <= 32'((dt_sq_q + 64'h0000_0001_0000_0000) >> 33);
		coef_q.beta <= (beta_q > nmk_pkg::COEF_ONE) ? nmk_pkg::COEF_ONE : beta_q;
		coef_q.gamma <= (gamma_q > nmk_pkg::COEF_ONE) ? nmk_pkg::COEF_ONE : gamma_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == IDX_W'(NUM_DOF - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	assign adv    = ~out_vld_q | m_tready;
	assign hazard = r_ctl.valid &
		((d_ctl_s1.valid & d_ctl_s1.func & (d_idx_s1 == r_idx)) | upd_conflict);
	assign div_en = adv & ~hazard;
	assign s_tready = div_en & ~clr_busy_q;

	nmk_div #(
		.FRAC_BITS (FRAC_BITS),
		.NUM_DOF   (NUM_DOF),
		.IDX_W     (IDX_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (div_en),
		.in_valid (s_tvalid & ~clr_busy_q),
		.in_func  (s_tuser[0]),
		.in_dof   (s_tdata[11:0]),
		.in_res   (s_tdata[43:12]),
		.in_mass  (s_tdata[75:44]),
		.out_ctl  (r_ctl),
		.out_idx  (r_idx),
		.out_an   (r_an)
	);

	// Store read stage; a blocked transaction puts a bubble into this stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_ctl_s1 <= '0;
		end else if (adv) begin
			d_ctl_s1 <= r_ctl;
			if (hazard) begin
				d_ctl_s1.valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_en) begin
			d_idx_s1 <= r_idx;
			d_an_s1  <= r_an;
			d_u_s1   <= disp_mem[r_idx];
			d_v_s1   <= vel_mem[r_idx];
			d_a_s1   <= accel_mem[r_idx];
		end
	end

	assign we      = clr_busy_q | (adv & g_ctl.valid & g_ctl.func);
	assign wr_addr = clr_busy_q ? clr_addr_q : g_idx;
	assign wr_u    = clr_busy_q ? 32'd0 : g_u;
	assign wr_v    = clr_busy_q ? 32'd0 : g_v;
	assign wr_a    = clr_busy_q ? 32'd0 : g_a;

	always_ff @(posedge clk) begin
		if (we) begin
			disp_mem[wr_addr]  <= wr_u;
			vel_mem[wr_addr]   <= wr_v;
			accel_mem[wr_addr] <= wr_a;
		end
	end

	nmk_update #(
		.IDX_W (IDX_W)
	) u_update (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.coef      (coef_q),
		.d_ctl     (d_ctl_s1),
		.d_idx     (d_idx_s1),
		.d_an      (d_an_s1),
		.d_u       (d_u_s1),
		.d_v       (d_v_s1),
		.d_a       (d_a_s1),
		.probe_idx (r_idx),
		.conflict  (upd_conflict),
		.g_ctl     (g_ctl),
		.g_idx     (g_idx),
		.g_u       (g_u),
		.g_v       (g_v),
		.g_a       (g_a),
		.g_sat     (g_sat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= g_ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && g_ctl.valid) begin
			out_data_q <= {g_a, g_v, g_u};
			out_sat_q  <= g_sat;
		end
	end

	assign m_tvalid   = out_vld_q;
	assign m_tdata    = out_data_q;
	assign m_tuser[0] = out_sat_q;

endmodule

`default_nettype wire

// ===== sv/nmk_checker.sv =====
// ============================================================================
// nmk_checker: port level checks of the Newmark integrator
// Watches the result stream and the input ready against the output stall.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module nmk_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [95:0] m_tdata,
	input wire logic [0:0]  m_tuser
);

	// A stalled result transaction holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// The pipeline never takes input while its output is blocked.
	a_no_take_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (!m_tvalid || m_tready))
		else $error("input accepted while output stalled");

	// A clipped result shows at least one value at a range limit.
	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |->
			(m_tdata[31:0] == 32'h7FFF_FFFF) || (m_tdata[31:0] == 32'h8000_0000) ||
			(m_tdata[63:32] == 32'h7FFF_FFFF) || (m_tdata[63:32] == 32'h8000_0000) ||
			(m_tdata[95:64] == 32'h7FFF_FFFF) || (m_tdata[95:64] == 32'h8000_0000))
		else $error("saturation flag without a clipped value");

endmodule

bind newmark_dof_integrator nmk_checker u_nmk_checker (.*);

`default_nettype wire
